// ----- rtl/sbd_pkg.sv -----
package sbd_pkg;

    localparam int unsigned WINDOW_BYTES_DEF = 65536;
    localparam int unsigned POS_W = 32;
    localparam int unsigned HDR_BYTES_MAX = 5;
    localparam logic [6:0] LIT_INLINE_MAX = 7'd60;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TAG,
        PH_LITLEN,
        PH_LITERAL,
        PH_COPYOFF
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUNNING   = 3'd0,
        ST_DONE_OK   = 3'd1,
        ST_BAD_HDR   = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_BAD_OFS   = 3'd4,
        ST_OVERFLOW  = 3'd5,
        ST_TRUNCATED = 3'd6,
        ST_SHORT     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        TAG_LITERAL = 2'd0,
        TAG_COPY1   = 2'd1,
        TAG_COPY2   = 2'd2,
        TAG_COPY4   = 2'd3
    } tag_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CP_RD,
        S_CP_WR
    } ctl_state_t;

    // What one accepted byte asks of the datapath
    typedef struct packed {
        logic             emit;
        logic             copy_go;
        logic [6:0]       copy_len;
        logic [POS_W-1:0] copy_dist;
        logic [POS_W-1:0] pos;
        status_t          status;
    } step_t;

endpackage

// ----- rtl/sbd_ifs.sv -----
interface sbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;
    modport source (output valid, in_byte, end_of_stream, input ready);
    modport sink (input valid, in_byte, end_of_stream, output ready);
endinterface

interface sbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic [2:0] stream_status;
    logic       last;
    modport source (output valid, out_byte, has_byte, stream_status, last, input ready);
    modport sink (input valid, out_byte, has_byte, stream_status, last, output ready);
endinterface

interface sbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] expected_length;
    modport source (output valid, expected_length, input ready);
    modport sink (input valid, expected_length, output ready);
endinterface

// ----- rtl/sbd_ram.sv -----
module sbd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/sbd_decode.sv -----
module sbd_decode
    import sbd_pkg::*;
#(
    parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             end_of_stream,
    input  logic [POS_W-1:0] expected_length,
    output step_t            step
);

    localparam logic [POS_W:0] WIN = (POS_W+1)'(WINDOW_BYTES);

    phase_t           phase_reg, phase_next;
    logic [34:0]      hv_reg, hv_next;
    logic [2:0]       hc_reg, hc_next;
    logic [32:0]      pend_reg, pend_next;
    logic [2:0]       extra_reg, extra_next;
    logic [1:0]       idx_reg, idx_next;
    logic [POS_W-1:0] ofs_reg, ofs_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             err_reg, err_next;
    status_t          ecode_reg, ecode_next;

    logic [34:0] hv_add;
    logic [6:0]  lit_len;
    logic [32:0] addend;
    logic [33:0] sum;
    logic        over;
    status_t     code;
    logic        found;

    always_comb
    begin
        case (hc_reg)
            3'd0: hv_add = 35'(in_byte[6:0]);
            3'd1: hv_add = 35'(in_byte[6:0]) << 7;
            3'd2: hv_add = 35'(in_byte[6:0]) << 14;
            3'd3: hv_add = 35'(in_byte[6:0]) << 21;
            default: hv_add = 35'(in_byte[6:0]) << 28;
        endcase
    end

    assign lit_len = {1'b0, in_byte[7:2]} + 7'd1;

    // one shared length check: position plus the run about to be produced
    always_comb
    begin
        case (phase_reg)
            PH_TAG:     addend = 33'(lit_len);
            PH_LITLEN:  addend = (pend_reg | (33'(in_byte) << {idx_reg, 3'b000})) + 33'd1;
            PH_COPYOFF: addend = pend_reg;
            default:    addend = 33'd0;
        endcase
        sum  = {2'b00, pos_reg} + {1'b0, addend};
        over = sum > {2'b00, expected_length};
    end

    always_comb
    begin
        phase_next = phase_reg;
        hv_next    = hv_reg;
        hc_next    = hc_reg;
        pend_next  = pend_reg;
        extra_next = extra_reg;
        idx_next   = idx_reg;
        ofs_next   = ofs_reg;
        pos_next   = pos_reg;
        err_next   = err_reg;
        ecode_next = ecode_reg;
        code       = ST_RUNNING;
        found      = 1'b0;
        step       = '0;
        step.pos       = pos_reg;
        step.copy_dist = ofs_reg;
        step.copy_len  = pend_reg[6:0];

        if (!err_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    hv_next = hv_reg | hv_add;
                    hc_next = hc_reg + 3'd1;
                    if (!in_byte[7])
                    begin
                        if (hv_next[34:32] != 3'd0)
                        begin
                            found = 1'b1;
                            code  = ST_BAD_HDR;
                        end
                        else if (hv_next[31:0] != expected_length)
                        begin
                            found = 1'b1;
                            code  = ST_MISMATCH;
                        end
                        else
                        begin
                            phase_next = PH_TAG;
                        end
                    end
                    else if (hc_next >= 3'(HDR_BYTES_MAX))
                    begin
                        found = 1'b1;
                        code  = ST_BAD_HDR;
                    end
                end
                PH_TAG:
                begin
                    ofs_next = '0;
                    idx_next = 2'd0;
                    case (tag_t'(in_byte[1:0]))
                        TAG_LITERAL:
                        begin
                            if (lit_len > LIT_INLINE_MAX)
                            begin
                                extra_next = 3'(lit_len - LIT_INLINE_MAX);
                                pend_next  = '0;
                                phase_next = PH_LITLEN;
                            end
                            else if (over)
                            begin
                                pend_next = 33'(lit_len);
                                found     = 1'b1;
                                code      = ST_OVERFLOW;
                            end
                            else
                            begin
                                pend_next  = 33'(lit_len);
                                phase_next = PH_LITERAL;
                            end
                        end
                        TAG_COPY1:
                        begin
                            pend_next  = 33'd4 + 33'(in_byte[4:2]);
                            ofs_next   = POS_W'(in_byte[7:5]) << 8;
                            extra_next = 3'd1;
                            phase_next = PH_COPYOFF;
                        end
                        TAG_COPY2:
                        begin
                            pend_next  = 33'(lit_len);
                            extra_next = 3'd2;
                            phase_next = PH_COPYOFF;
                        end
                        default:
                        begin
                            pend_next  = 33'(lit_len);
                            extra_next = 3'd4;
                            phase_next = PH_COPYOFF;
                        end
                    endcase
                end
                PH_LITLEN:
                begin
                    pend_next  = pend_reg | (33'(in_byte) << {idx_reg, 3'b000});
                    idx_next   = idx_reg + 2'd1;
                    extra_next = extra_reg - 3'd1;
                    if (extra_next == 3'd0)
                    begin
                        pend_next = addend;
                        if (over)
                        begin
                            found = 1'b1;
                            code  = ST_OVERFLOW;
                        end
                        else
                        begin
                            phase_next = PH_LITERAL;
                        end
                    end
                end
                PH_LITERAL:
                begin
                    step.emit = 1'b1;
                    pos_next  = pos_reg + POS_W'(1);
                    pend_next = pend_reg - 33'd1;
                    if (pend_next == 33'd0)
                    begin
                        phase_next = PH_TAG;
                    end
                end
                PH_COPYOFF:
                begin
                    ofs_next       = ofs_reg | (POS_W'(in_byte) << {idx_reg, 3'b000});
                    step.copy_dist = ofs_next;
                    idx_next       = idx_reg + 2'd1;
                    extra_next     = extra_reg - 3'd1;
                    if (extra_next == 3'd0)
                    begin
                        if (ofs_next == '0 || ofs_next > pos_reg
                            || {1'b0, ofs_next} > WIN)
                        begin
                            found = 1'b1;
                            code  = ST_BAD_OFS;
                        end
                        else if (over)
                        begin
                            found = 1'b1;
                            code  = ST_OVERFLOW;
                        end
                        else
                        begin
                            step.copy_go = 1'b1;
                            pos_next     = sum[POS_W-1:0];
                            phase_next   = PH_TAG;
                        end
                    end
                end
                default:
                begin
                    found = 1'b1;
                    code  = ST_TRUNCATED;
                end
            endcase
            if (found)
            begin
                err_next   = 1'b1;
                ecode_next = code;
            end
        end

        if (err_next)
        begin
            step.status = ecode_next;
        end
        else if (end_of_stream)
        begin
            if (phase_next == PH_HEADER)
                step.status = ST_BAD_HDR;
            else if (phase_next != PH_TAG)
                step.status = ST_TRUNCATED;
            else if (pos_next < expected_length)
                step.status = ST_SHORT;
            else if (pos_next > expected_length)
                step.status = ST_OVERFLOW;
            else
                step.status = ST_DONE_OK;
        end
        else
        begin
            step.status = ST_RUNNING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hv_reg    <= '0;
            hc_reg    <= '0;
            pend_reg  <= '0;
            extra_reg <= '0;
            idx_reg   <= '0;
            ofs_reg   <= '0;
            pos_reg   <= '0;
            err_reg   <= 1'b0;
            ecode_reg <= ST_RUNNING;
        end
        else if (accept)
        begin
            if (end_of_stream)
            begin
                phase_reg <= PH_HEADER;
                hv_reg    <= '0;
                hc_reg    <= '0;
                pend_reg  <= '0;
                extra_reg <= '0;
                idx_reg   <= '0;
                ofs_reg   <= '0;
                pos_reg   <= '0;
                err_reg   <= 1'b0;
                ecode_reg <= ST_RUNNING;
            end
            else
            begin
                phase_reg <= phase_next;
                hv_reg    <= hv_next;
                hc_reg    <= hc_next;
                pend_reg  <= pend_next;
                extra_reg <= extra_next;
                idx_reg   <= idx_next;
                ofs_reg   <= ofs_next;
                pos_reg   <= pos_next;
                err_reg   <= err_next;
                ecode_reg <= ecode_next;
            end
        end
    end

endmodule

// ----- rtl/snappy_block_decompressor.sv -----
// A header, tag or literal result is registered when its input byte is taken;
// the first byte of a copy follows its last tag byte through S_CP_RD (history
// RAM read) and S_CP_WR (write-back and output, held while the output stalls).
// Header, tag and literal bytes are taken whenever the output is free; a copy
// holds the input while each copied byte is read from the history RAM, then written back.
// Reset (rst_n low, async) clears the parser, config and output valid; history
// RAM is not cleared and needs no clearing pass.
module snappy_block_decompressor
    import sbd_pkg::*;
#(
    parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
    input logic         clk,
    input logic         rst_n,
    sbd_cfg_if.sink     cfg,
    sbd_in_if.sink      stream,
    sbd_out_if.source   decoded
);

    localparam int unsigned AW = $clog2(WINDOW_BYTES);

    ctl_state_t  state_reg, state_next;
    logic [31:0] exp_reg;
    step_t       step;
    logic        acc;
    logic        out_free;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          has_byte_reg, has_byte_next;
    status_t       status_reg, status_next;
    logic          last_reg, last_next;

    logic [6:0]    cp_left_reg, cp_left_next;
    logic [AW-1:0] cp_pos_reg, cp_pos_next;
    logic [AW-1:0] cp_dist_reg, cp_dist_next;
    status_t       cp_status_reg, cp_status_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= '0;
        end
        else if (cfg.valid)
        begin
            exp_reg <= cfg.expected_length;
        end
    end

    assign out_free     = !out_valid_reg || decoded.ready;
    assign stream.ready = (state_reg == S_IDLE) && out_free;
    assign acc          = stream.valid && stream.ready;

    sbd_decode #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (acc),
        .in_byte         (stream.in_byte),
        .end_of_stream   (stream.end_of_stream),
        .expected_length (exp_reg),
        .step            (step)
    );

    sbd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // window size is a power of two, so the source wraps by masking
    assign ram_raddr = cp_pos_reg - cp_dist_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !decoded.ready;
        out_byte_next  = out_byte_reg;
        has_byte_next  = has_byte_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        cp_left_next   = cp_left_reg;
        cp_pos_next    = cp_pos_reg;
        cp_dist_next   = cp_dist_reg;
        cp_status_next = cp_status_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = step.pos[AW-1:0];
        ram_wdata      = stream.in_byte;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (step.copy_go)
                    begin
                        cp_left_next   = step.copy_len;
                        cp_pos_next    = step.pos[AW-1:0];
                        cp_dist_next   = step.copy_dist[AW-1:0];
                        cp_status_next = step.status;
                        state_next     = S_CP_RD;
                    end
                    else
                    begin
                        ram_we         = step.emit;
                        out_valid_next = 1'b1;
                        out_byte_next  = step.emit ? stream.in_byte : 8'd0;
                        has_byte_next  = step.emit;
                        status_next    = step.status;
                        last_next      = 1'b1;
                    end
                end
            end
            S_CP_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = cp_pos_reg;
                    ram_wdata      = ram_rdata;
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    has_byte_next  = 1'b1;
                    status_next    = cp_status_reg;
                    last_next      = (cp_left_reg == 7'd1);
                    cp_left_next   = cp_left_reg - 7'd1;
                    cp_pos_next    = cp_pos_reg + AW'(1);
                    state_next     = (cp_left_reg == 7'd1) ? S_IDLE : S_CP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cp_left_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cp_left_reg   <= cp_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        has_byte_reg  <= has_byte_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
        cp_pos_reg    <= cp_pos_next;
        cp_dist_reg   <= cp_dist_next;
        cp_status_reg <= cp_status_next;
    end

    assign decoded.valid         = out_valid_reg;
    assign decoded.out_byte      = out_byte_reg;
    assign decoded.has_byte      = has_byte_reg;
    assign decoded.stream_status = status_reg;
    assign decoded.last          = last_reg;

    a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid && !decoded.has_byte |-> decoded.last && decoded.out_byte == 8'd0)
        else $error("result without byte must be final and zero");

    a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CP_WR |-> $past(state_reg) == S_CP_RD || $past(state_reg) == S_CP_WR)
        else $error("copy write-back without a read");

    a_copy_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> cp_left_reg != 7'd0)
        else $error("copy running with nothing left");

    a_copy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        acc && step.copy_go |=> !stream.ready)
        else $error("input taken during copy");

endmodule
